// ===== src/cgpc_pkg.sv =====
// Package: item types, CRC-15 constants and CRC helper functions for the PEC checker.
package cgpc_pkg;

  // Frame layout
  localparam int unsigned DataLen  = 6;
  localparam int unsigned FrameLen = 8;
  localparam logic [2:0]  PosPecHi = 3'd6;
  localparam logic [2:0]  PosPecLo = 3'd7;

  // CRC-15 polynomial and seed
  localparam logic [15:0] CrcPoly = 16'h4599;
  localparam logic [15:0] CrcSeed = 16'd16;

  // Input item
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
    logic [1:0] group_index;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [15:0] cell_code_first;
    logic [15:0] cell_code_second;
    logic [15:0] cell_code_third;
    logic [1:0]  group_out;
    logic        pec_mismatch;
  } out_item_t;

  // One table entry of the byte-wise CRC-15, eight shift/xor steps
  function automatic logic [15:0] crc15_entry(input logic [7:0] idx);
    logic [15:0] r;
    r = {1'b0, idx, 7'd0};
    for (int b = 0; b < 8; b++) begin
      if (r[14]) begin
        r = {r[14:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Fold one byte into the running remainder
  function automatic logic [15:0] crc15_update(input logic [15:0] rem, input logic [7:0] data);
    logic [7:0] addr;
    addr = rem[14:7] ^ data;
    return {rem[7:0], 8'd0} ^ crc15_entry(addr);
  endfunction

endpackage

// ===== src/cgpc_frame_core.sv =====
// Frame assembly: byte position, data bytes, running CRC and the PEC compare.
module cgpc_frame_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  cgpc_pkg::in_item_t  item,
  output logic              res_valid,
  output cgpc_pkg::out_item_t res
);
  import cgpc_pkg::*;

  logic [2:0]       byte_count_r, byte_count_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [5:0][7:0]  data_r, data_nxt;
  logic [7:0]       pec_hi_r, pec_hi_nxt;

  logic [2:0]       pos;
  logic [15:0]      crc_cur;
  logic [15:0]      pec_rx;
  logic [15:0]      pec_calc;

  // A start marker drops any partial frame
  assign pos     = item.frame_start ? 3'd0 : byte_count_r;
  assign crc_cur = item.frame_start ? CrcSeed : crc_r;

  // Received PEC is big endian; the computed one is the remainder doubled
  assign pec_rx   = {pec_hi_r, item.rx_byte};
  assign pec_calc = {crc_cur[14:0], 1'b0};

  // Next-state logic per byte position
  always_comb begin
    byte_count_nxt = byte_count_r;
    crc_nxt        = crc_r;
    data_nxt       = data_r;
    pec_hi_nxt     = pec_hi_r;
    res_valid      = 1'b0;
    if (acc) begin
      if (pos < PosPecHi) begin
        data_nxt[pos]  = item.rx_byte;
        crc_nxt        = crc15_update(crc_cur, item.rx_byte);
        byte_count_nxt = pos + 3'd1;
      end else if (pos == PosPecHi) begin
        pec_hi_nxt     = item.rx_byte;
        crc_nxt        = crc_cur;
        byte_count_nxt = PosPecLo;
      end else begin
        // last byte: emit and reopen the frame
        res_valid      = 1'b1;
        crc_nxt        = CrcSeed;
        byte_count_nxt = 3'd0;
      end
    end
  end

  // Result fields for the last byte
  always_comb begin
    res.cell_code_first  = {data_r[1], data_r[0]};
    res.cell_code_second = {data_r[3], data_r[2]};
    res.cell_code_third  = {data_r[5], data_r[4]};
    res.group_out        = item.group_index;
    res.pec_mismatch     = (pec_rx != pec_calc);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= 3'd0;
      crc_r        <= CrcSeed;
    end else begin
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    data_r   <= data_nxt;
    pec_hi_r <= pec_hi_nxt;
  end

endmodule

// ===== src/cell_group_pec_checker.sv =====
// Top level: register group PEC checker with an output register and skid stage.
// A result from the eighth accepted byte of a frame is registered on out_, or in the skid stage while out_ is held.
// Throughput: one byte item per cycle while in_stall is low; the byte-wide CRC-15 update is one table lookup per cycle.
// in_stall is registered and rises only when the output register is held and a second
// result is parked in the skid stage.
// Reset (rst_n low, synchronous): byte count cleared, CRC back to seed, both result stages empty.
module cell_group_pec_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cgpc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output cgpc_pkg::out_item_t out_item
);
  import cgpc_pkg::*;

  logic      acc;
  logic      res_valid;
  out_item_t res;

  logic      out_valid_r;
  out_item_t out_item_r;
  logic      skid_valid_r;
  out_item_t skid_item_r;

  assign acc = in_valid && !in_stall;

  // Frame assembly and CRC
  cgpc_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .item      (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register with a one-entry skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Result payload moves
  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_item_r <= skid_valid_r ? skid_item_r : res;
    end
    if (out_valid_r && out_stall && res_valid) begin
      skid_item_r <= res;
    end
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== src/cgpc_checker.sv =====
// Port-level checker for the PEC checker handshakes, bound to the top level.
module cgpc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  // Input stalls only when a result is held at the output
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall high with no result held");

  // The stall only starts after a held output cycle
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("in_stall rose without a held result");

  // A fresh result follows an accepted item
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result appeared without an accepted item");

  // A held result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

endmodule

bind cell_group_pec_checker cgpc_checker u_cgpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

// ===== test/pec_frame_check.sv =====
// PEC fold helpers and the monitor that predicts and checks register group results.
package cgpc_tb_pkg;

  // One data byte folded into the CRC-15 remainder, shift and reduce merged
  function automatic logic [15:0] pec_fold(input logic [15:0] rem, input logic [7:0] data);
    logic [15:0] acc;
    acc = {1'b0, rem[14:7] ^ data, 7'b0};
    repeat (8) acc = {acc[14:0], 1'b0} ^ (acc[14] ? cgpc_pkg::CrcPoly : 16'h0000);
    return {rem[7:0], 8'h00} ^ acc;
  endfunction

  // PEC that the sender puts after these six data bytes
  function automatic logic [15:0] frame_pec(input logic [5:0][7:0] data);
    logic [15:0] rem;
    rem = cgpc_pkg::CrcSeed;
    for (int i = 0; i < 6; i++) rem = pec_fold(rem, data[i]);
    return {rem[14:0], 1'b0};
  endfunction

endpackage

module pec_frame_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  cgpc_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  cgpc_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending,
  output int                  frames_seen,
  output int                  bad_pec_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import cgpc_pkg::*;
  import cgpc_tb_pkg::*;

  // Predicted frame state
  logic [2:0]      byte_pos;
  logic [15:0]     crc_rem;
  logic [5:0][7:0] cell_bytes;
  logic [7:0]      pec_hi;
  out_item_t       expected_frames[$];

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t  exp_item;
    logic [2:0] pos;
    if (!rst_n) begin
      byte_pos   = 3'd0;
      crc_rem    = CrcSeed;
      cell_bytes = '0;
      pec_hi     = 8'h00;
      expected_frames.delete();
    end else begin
      // fold an accepted byte into the prediction
      if (in_valid && !in_stall) begin
        if (in_item.frame_start) begin
          byte_pos = 3'd0;
          crc_rem  = CrcSeed;
        end
        pos = byte_pos;
        if (pos < PosPecHi) begin
          cell_bytes[pos] = in_item.rx_byte;
          crc_rem         = pec_fold(crc_rem, in_item.rx_byte);
          byte_pos        = pos + 3'd1;
        end else if (pos == PosPecHi) begin
          pec_hi   = in_item.rx_byte;
          byte_pos = PosPecLo;
        end else begin
          // last byte: the frame is complete
          exp_item.cell_code_first  = {cell_bytes[1], cell_bytes[0]};
          exp_item.cell_code_second = {cell_bytes[3], cell_bytes[2]};
          exp_item.cell_code_third  = {cell_bytes[5], cell_bytes[4]};
          exp_item.group_out        = in_item.group_index;
          exp_item.pec_mismatch     = ({pec_hi, in_item.rx_byte} != {crc_rem[14:0], 1'b0});
          expected_frames.push_back(exp_item);
          byte_pos = 3'd0;
          crc_rem  = CrcSeed;
        end
      end

      // compare an accepted result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          $error("result with no frame pending: %p", out_item);
          fail_count++;
        end else begin
          exp_item = expected_frames.pop_front();
          check_field("cell_code_first", exp_item.cell_code_first, out_item.cell_code_first);
          check_field("cell_code_second", exp_item.cell_code_second, out_item.cell_code_second);
          check_field("cell_code_third", exp_item.cell_code_third, out_item.cell_code_third);
          check_field("group_out", 16'(exp_item.group_out), 16'(out_item.group_out));
          check_field("pec_mismatch", 16'(exp_item.pec_mismatch), 16'(out_item.pec_mismatch));
          frames_seen++;
          if (exp_item.pec_mismatch) bad_pec_seen++;
        end
      end
    end
    pending = expected_frames.size();
  end

endmodule

// ===== test/tb_cell_group_pec_checker.sv =====
// Testbench top: clock, reset, byte stream stimulus, output stalls and the verdict.
module tb_cell_group_pec_checker;
  timeunit 1ns;
  timeprecision 1ps;

  import cgpc_pkg::*;
  import cgpc_tb_pkg::*;

  localparam int HoldCycles = 240;
  localparam int CycleLimit = 200000;
  localparam int TailCycles = 16;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  int fail_count;
  int pending;
  int frames_seen;
  int bad_pec_seen;
  int items_sent     = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_req_cnt   = 0;
  int hold_done_cnt  = 0;
  int hold_left      = 0;
  int cycle_count    = 0;

  always #6 clk = ~clk;

  cell_group_pec_checker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  pec_frame_check mon (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item),
    .fail_count   (fail_count),
    .pending      (pending),
    .frames_seen  (frames_seen),
    .bad_pec_seen (bad_pec_seen)
  );

  // Result side: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_req_cnt != hold_done_cnt) begin
      hold_left     = HoldCycles;
      hold_done_cnt = hold_req_cnt;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One byte item, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] rx, input logic start, input logic [1:0] grp);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{rx_byte: rx, frame_start: start, group_index: grp};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Full frame; the group index only matters on the last byte
  task automatic send_frame(input logic [5:0][7:0] data, input logic [15:0] pec,
                            input logic [1:0] grp, input logic start);
    logic [7:0][7:0] fb;
    fb = {pec[7:0], pec[15:8], data};
    for (int i = 0; i < 8; i++) begin
      send_byte(fb[i], start && (i == 0), (i == 7) ? grp : 2'($urandom_range(3)));
    end
  endtask

  // Sender holds off until every predicted result has arrived
  task automatic drain_results;
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  // Mostly clean frames with random content, plus bad PECs, lost markers, truncated frames and noise
  task automatic run_random(input int quota);
    int              stop_at;
    int              kind;
    int              cut;
    logic [5:0][7:0] data;
    logic [15:0]     pec;
    logic [1:0]      grp;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      data = {16'($urandom), $urandom};
      pec  = frame_pec(data);
      grp  = 2'($urandom_range(3));
      kind = $urandom_range(99);
      if (kind < 70) begin
        send_frame(data, pec, grp, 1'b1);
      end else if (kind < 80) begin
        send_frame(data, pec ^ (16'h0001 << $urandom_range(15)), grp, 1'b1);
      end else if (kind < 88) begin
        send_frame(data, pec, grp, 1'b0);
      end else if (kind < 95) begin
        // truncated frame, later dropped by a start marker or misaligning the stream
        cut = $urandom_range(7, 1);
        for (int i = 0; i < cut; i++) begin
          send_byte(8'($urandom), i == 0, 2'($urandom_range(3)));
        end
      end else begin
        repeat ($urandom_range(10, 1)) begin
          send_byte(8'($urandom), $urandom_range(9) == 0, 2'($urandom_range(3)));
        end
      end
    end
  endtask

  initial begin
    logic [5:0][7:0] mixed;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: all-zero frame with good PEC, then an all-ones frame with a bad PEC
    // that opens without a start marker right after the previous frame ended
    send_frame('0, frame_pec('0), 2'd3, 1'b1);
    send_frame({6{8'hff}}, 16'hffff, 2'd0, 1'b0);
    // start marker in the middle of a frame drops the partial one
    send_byte(8'ha5, 1'b1, 2'd3);
    send_byte(8'h5a, 1'b0, 2'd1);
    send_byte(8'h3c, 1'b0, 2'd2);
    mixed = 48'h80_01_7f_fe_00_ff;
    send_frame(mixed, frame_pec(mixed), 2'd2, 1'b1);
    drain_results();

    // phase one: sender idles a little, receiver stalls a lot
    send_gap_pct   = 13;
    recv_stall_pct = 74;
    run_random(460);
    drain_results();

    // phase two: the other way round
    send_gap_pct   = 74;
    recv_stall_pct = 13;
    run_random(460);
    drain_results();

    // phase three: no idling, opened by a long output hold to back up the input
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_req_cnt++;
    run_random(480);
    drain_results();

    repeat (TailCycles) @(posedge clk);
    $display("Sent %0d byte items; %0d frames checked, %0d of them with a bad PEC.",
             items_sent, frames_seen, bad_pec_seen);
    $display("Stall mixes: light/heavy, heavy/light, none, plus one long output hold.");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
